// ===== src/plc_pkg.sv =====
// package for the positional list engine: request and result types,
// command and status codes, default sizes; no dependencies
`timescale 1ns / 1ps

package plc_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 8;
  localparam int POS_W          = 7;
  localparam int ITEM_W         = 8;
  localparam int LEN_W          = 7;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_RETRIEVE = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              command;
    logic [POS_W-1:0]  position;
    logic [ITEM_W-1:0] item;
  } req_t;

  typedef struct packed {
    logic [ITEM_W-1:0] data;
    status_t           status;
    logic [LEN_W-1:0]  length;
    logic              is_empty;
  } res_t;

  // shift control broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

// ===== src/plc_cell.sv =====
// one storage cell of the list chain: holds one item, shifts from its
// left or right neighbor; depends on plc_pkg
`timescale 1ns / 1ps

module plc_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int DW  = plc_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  plc_pkg::cell_ctl_t ctl,
  input  logic [IW-1:0]     p0,
  input  logic [DW-1:0]     item,
  input  logic [DW-1:0]     left,
  input  logic [DW-1:0]     right,
  output logic [DW-1:0]     q,
  output logic [DW-1:0]     hit_data
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [DW-1:0] data_r;
  logic [DW-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (MY_IDX > p0) begin
        data_nxt = left;
      end else if (MY_IDX == p0) begin
        data_nxt = item;
      end
    end else if (ctl.del) begin
      if (MY_IDX >= p0) begin
        data_nxt = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q        = data_r;
  assign hit_data = (MY_IDX == p0) ? data_r : '0;

endmodule

// ===== src/positional_list_engine_core.sv =====
// top level of the positional list engine: command decode, fill count and
// the chain of plc_cell storage cells; depends on plc_pkg and plc_cell
`timescale 1ns / 1ps

// Usage
//   A request (command, position, item) is taken at a rising edge where start
//   is high and busy is low. busy is never raised: a request can be taken in
//   every cycle, so the sustained rate is one request per clock.
//   The result (data, status, length, is_empty) appears on out_res in the cycle
//   after the request is taken, with out_valid high for exactly that cycle.
//   The whole chain of cells shifts in parallel in the edge that takes the
//   request, and retrieve reads the matching cell through an or-tree across
//   the chain.
//   Insert shifts cells at and after the position one place right, delete
//   shifts them one place left; positions are 1-based.
//   Reset (rst_n low, synchronous) empties the list and drops out_valid; cell
//   contents are not cleared since only positions inside the list are read.
//   The receiver cannot stall; each result must be taken in its cycle.

module positional_list_engine_core #(
  parameter int CAPACITY   = plc_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = plc_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  plc_pkg::req_t in_req,
  output logic          out_valid,
  output plc_pkg::res_t out_res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int W  = ((CW > plc_pkg::POS_W) ? CW : plc_pkg::POS_W) + 1;

  logic [CW-1:0] fill_r;
  logic [CW-1:0] fill_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  plc_pkg::res_t out_res_r;
  plc_pkg::res_t out_res_nxt;

  logic               accept;
  logic [W-1:0]       pos_w;
  logic [W-1:0]       fill_w;
  logic [IW-1:0]      p0;
  logic               is_ins;
  logic               is_del;
  logic               is_rd;
  logic               ins_range_bad;
  logic               rd_range_bad;
  logic               full;
  logic               empty;
  logic               ins_ok;
  logic               del_ok;
  logic               rd_ok;
  plc_pkg::status_t   status;
  plc_pkg::cell_ctl_t ctl;
  logic [DATA_WIDTH-1:0] item_ext;
  logic [DATA_WIDTH-1:0] q    [CAPACITY];
  logic [DATA_WIDTH-1:0] hit  [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_w    = W'(in_req.position);
  assign fill_w   = W'(fill_r);
  assign p0       = IW'(pos_w - W'(1));
  assign item_ext = DATA_WIDTH'(in_req.item);

  assign is_ins = (in_req.command == plc_pkg::CMD_INSERT);
  assign is_del = (in_req.command == plc_pkg::CMD_DELETE);
  assign is_rd  = (in_req.command == plc_pkg::CMD_RETRIEVE);

  assign empty         = (fill_r == '0);
  assign full          = (fill_r == CW'(CAPACITY));
  assign ins_range_bad = (pos_w == '0) || (pos_w > fill_w + W'(1));
  assign rd_range_bad  = (pos_w == '0) || (pos_w > fill_w);

  assign ins_ok = accept && is_ins && !ins_range_bad && !full;
  assign del_ok = accept && is_del && !empty && !rd_range_bad;
  assign rd_ok  = is_rd && !empty && !rd_range_bad;

  always_comb begin
    status = plc_pkg::ST_OK;
    case (in_req.command)
      plc_pkg::CMD_INSERT: begin
        if (ins_range_bad) begin
          status = plc_pkg::ST_RANGE;
        end else if (full) begin
          status = plc_pkg::ST_FULL;
        end
      end
      plc_pkg::CMD_DELETE, plc_pkg::CMD_RETRIEVE: begin
        if (empty) begin
          status = plc_pkg::ST_EMPTY;
        end else if (rd_range_bad) begin
          status = plc_pkg::ST_RANGE;
        end
      end
      default: begin
        status = plc_pkg::ST_OK;
      end
    endcase
  end

  assign ctl.ins = ins_ok;
  assign ctl.del = del_ok;

  genvar g;
  for (g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;
    if (g == 0) begin : g_first
      assign left = item_ext;
    end else begin : g_mid_l
      assign left = q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = q[g+1];
    end
    plc_cell #(
      .IDX (g),
      .IW  (IW),
      .DW  (DATA_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .p0       (p0),
      .item     (item_ext),
      .left     (left),
      .right    (right),
      .q        (q[g]),
      .hit_data (hit[g])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | hit[i];
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (ins_ok) begin
      fill_nxt = fill_r + CW'(1);
    end else if (del_ok) begin
      fill_nxt = fill_r - CW'(1);
    end else if (accept && (in_req.command == plc_pkg::CMD_CLEAR)) begin
      fill_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt        = accept;
    out_res_nxt.data     = rd_ok ? plc_pkg::ITEM_W'(rd_data) : '0;
    out_res_nxt.status   = status;
    out_res_nxt.length   = plc_pkg::LEN_W'(fill_nxt);
    out_res_nxt.is_empty = (fill_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== src/plc_checker.sv =====
// port-level checks for positional_list_engine_core, attached by bind;
// depends on plc_pkg
`timescale 1ns / 1ps

module plc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input plc_pkg::req_t in_req,
  input logic          out_valid,
  input plc_pkg::res_t out_res
);

  // every request yields one result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without request");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.is_empty == (out_res.length == '0)))
    else $error("empty flag disagrees with length");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.status != plc_pkg::ST_OK) |-> (out_res.data == '0))
    else $error("data on failed request");

  // clear always empties the list
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req.command == plc_pkg::CMD_CLEAR)
    |=> out_res.is_empty && (out_res.status == plc_pkg::ST_OK))
    else $error("clear left items");

endmodule

bind positional_list_engine_core plc_checker u_plc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);

// ===== tb/positional_list_engine_core_checker.sv =====
// checker for the positional list engine: watches the request and result
// channels, keeps its own copy of the list and compares every result
// depends on plc_pkg
`timescale 1ns / 1ps

module positional_list_engine_core_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  plc_pkg::req_t in_req,
  input  logic          out_valid,
  input  plc_pkg::res_t out_res,
  output int            fail_count,
  output int            pending
);

  logic [plc_pkg::ITEM_W-1:0] list_items[$];
  plc_pkg::res_t              res_due[$];
  plc_pkg::res_t              exp_res;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // applies one request to the shadow list and returns the result it should give
  function automatic plc_pkg::res_t apply_list_cmd(input plc_pkg::req_t r);
    plc_pkg::res_t rr;
    int   pos;
    int   len;
    pos = int'(r.position);
    len = list_items.size();
    rr = '0;
    rr.status = plc_pkg::ST_OK;
    case (r.command)
      plc_pkg::CMD_INSERT: begin
        if (pos < 1 || pos > len + 1) begin
          rr.status = plc_pkg::ST_RANGE;
        end else if (len >= plc_pkg::CAPACITY_DEF) begin
          rr.status = plc_pkg::ST_FULL;
        end else begin
          list_items.insert(pos - 1, r.item);
        end
      end
      plc_pkg::CMD_DELETE: begin
        if (len == 0) begin
          rr.status = plc_pkg::ST_EMPTY;
        end else if (pos < 1 || pos > len) begin
          rr.status = plc_pkg::ST_RANGE;
        end else begin
          list_items.delete(pos - 1);
        end
      end
      plc_pkg::CMD_RETRIEVE: begin
        if (len == 0) begin
          rr.status = plc_pkg::ST_EMPTY;
        end else if (pos < 1 || pos > len) begin
          rr.status = plc_pkg::ST_RANGE;
        end else begin
          rr.data = list_items[pos - 1];
        end
      end
      default: begin
        list_items.delete();
      end
    endcase
    rr.length   = plc_pkg::LEN_W'(list_items.size());
    rr.is_empty = (list_items.size() == 0);
    return rr;
  endfunction

  task automatic report_field(input string name, input int exp_v, input int got_v);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      list_items.delete();
      res_due.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (res_due.size() == 0) begin
          fail_count++;
          $display("%0t: result with no request pending, actual %h", $time, out_res);
        end else begin
          exp_res = res_due.pop_front();
          if (out_res.data !== exp_res.data)
            report_field("data", exp_res.data, out_res.data);
          if (out_res.status !== exp_res.status)
            report_field("status", exp_res.status, out_res.status);
          if (out_res.length !== exp_res.length)
            report_field("length", exp_res.length, out_res.length);
          if (out_res.is_empty !== exp_res.is_empty)
            report_field("is_empty", exp_res.is_empty, out_res.is_empty);
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        res_due.push_back(apply_list_cmd(in_req));
      end
    end
    pending = res_due.size();
  end

endmodule

// ===== tb/positional_list_engine_core_test.sv =====
// testbench top for the positional list engine: clock, reset, directed and
// random requests with random gaps, final verdict
// depends on plc_pkg, positional_list_engine_core and its checker
`timescale 1ns / 1ps

module positional_list_engine_core_test;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  plc_pkg::req_t in_req;
  logic          out_valid;
  plc_pkg::res_t out_res;
  int            fail_count;
  int            pending;

  int   list_len;
  bit   gaps_on;

  positional_list_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  positional_list_engine_core_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("positional_list_engine_core_test: FAIL");
    $finish;
  end

  task automatic send_req(input plc_pkg::cmd_t c, input int pos,
                          input logic [plc_pkg::ITEM_W-1:0] itm);
    plc_pkg::req_t r;
    r.command  = c;
    r.position = pos[plc_pkg::POS_W-1:0];
    r.item     = itm;
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 38) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    // track length only to steer positions and the fill loop
    case (c)
      plc_pkg::CMD_INSERT:
        if (pos >= 1 && pos <= list_len + 1 && list_len < plc_pkg::CAPACITY_DEF) list_len++;
      plc_pkg::CMD_DELETE:
        if (list_len > 0 && pos >= 1 && pos <= list_len) list_len--;
      plc_pkg::CMD_CLEAR:
        list_len = 0;
      default: ;
    endcase
  endtask

  function automatic int pick_pos(input plc_pkg::cmd_t c);
    if ($urandom_range(0, 99) >= 85) return $urandom_range(0, 127);
    if (c == plc_pkg::CMD_INSERT) return $urandom_range(1, list_len + 1);
    return (list_len == 0) ? 1 : $urandom_range(1, list_len);
  endfunction

  function automatic plc_pkg::cmd_t pick_cmd(input int mode);
    int roll;
    int ins_w;
    int del_w;
    int ret_w;
    roll = $urandom_range(0, 99);
    case (mode)
      0:       begin ins_w = 70; del_w = 10; ret_w = 18; end
      1:       begin ins_w = 15; del_w = 65; ret_w = 18; end
      default: begin ins_w = 35; del_w = 30; ret_w = 32; end
    endcase
    if (roll < ins_w) return plc_pkg::CMD_INSERT;
    if (roll < ins_w + del_w) return plc_pkg::CMD_DELETE;
    if (roll < ins_w + del_w + ret_w) return plc_pkg::CMD_RETRIEVE;
    return plc_pkg::CMD_CLEAR;
  endfunction

  initial begin
    int            n;
    int            burst;
    int            mode;
    int            w;
    plc_pkg::cmd_t c;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_req   = '0;
    list_len = 0;
    gaps_on  = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty list and range corners
    send_req(plc_pkg::CMD_RETRIEVE, 1, 8'h11);
    send_req(plc_pkg::CMD_DELETE, 1, 8'h22);
    send_req(plc_pkg::CMD_DELETE, 0, 8'h33);
    send_req(plc_pkg::CMD_INSERT, 0, 8'h44);
    send_req(plc_pkg::CMD_INSERT, 2, 8'h55);
    send_req(plc_pkg::CMD_INSERT, 127, 8'h66);
    send_req(plc_pkg::CMD_INSERT, 1, 8'hFF);
    send_req(plc_pkg::CMD_INSERT, 1, 8'h00);
    send_req(plc_pkg::CMD_INSERT, 3, 8'hA5);
    send_req(plc_pkg::CMD_INSERT, 2, 8'h5A);
    send_req(plc_pkg::CMD_RETRIEVE, 0, 8'h00);
    for (int p = 1; p <= 5; p++) send_req(plc_pkg::CMD_RETRIEVE, p, 8'hFF);
    send_req(plc_pkg::CMD_DELETE, 5, 8'h00);
    send_req(plc_pkg::CMD_DELETE, 2, 8'h00);
    send_req(plc_pkg::CMD_DELETE, 3, 8'h00);
    send_req(plc_pkg::CMD_DELETE, 1, 8'h00);
    send_req(plc_pkg::CMD_RETRIEVE, 1, 8'h00);
    send_req(plc_pkg::CMD_CLEAR, 0, 8'h00);
    send_req(plc_pkg::CMD_CLEAR, 127, 8'hFF);
    send_req(plc_pkg::CMD_RETRIEVE, 1, 8'h00);

    // fill to capacity, then the full and over-range cases
    while (list_len < plc_pkg::CAPACITY_DEF)
      send_req(plc_pkg::CMD_INSERT, $urandom_range(1, list_len + 1),
               plc_pkg::ITEM_W'($urandom_range(0, 255)));
    send_req(plc_pkg::CMD_INSERT, plc_pkg::CAPACITY_DEF + 1, 8'h77);
    send_req(plc_pkg::CMD_INSERT, plc_pkg::CAPACITY_DEF + 2, 8'h78);
    send_req(plc_pkg::CMD_INSERT, 1, 8'h79);
    send_req(plc_pkg::CMD_RETRIEVE, plc_pkg::CAPACITY_DEF, 8'h00);
    send_req(plc_pkg::CMD_RETRIEVE, plc_pkg::CAPACITY_DEF + 1, 8'h00);
    send_req(plc_pkg::CMD_DELETE, plc_pkg::CAPACITY_DEF, 8'h00);
    send_req(plc_pkg::CMD_DELETE, plc_pkg::CAPACITY_DEF, 8'h00);

    n = 0;
    while (n < 1300) begin
      burst = $urandom_range(40, 100);
      mode  = $urandom_range(0, 2);
      for (int k = 0; k < burst && n < 1300; k++) begin
        gaps_on = !(n >= 500 && n < 800);
        c = pick_cmd(mode);
        send_req(c, pick_pos(c), plc_pkg::ITEM_W'($urandom_range(0, 255)));
        n++;
      end
    end

    @(negedge clk);
    start <= 1'b0;
    w = 0;
    while (pending != 0 && w < 1000) begin
      @(negedge clk);
      w++;
    end
    repeat (5) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("positional_list_engine_core_test: PASS");
    end else begin
      $display("positional_list_engine_core_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/plc_pkg.sv
src/plc_cell.sv
src/positional_list_engine_core.sv
src/plc_checker.sv
tb/positional_list_engine_core_checker.sv
tb/positional_list_engine_core_test.sv
